/* sv/prime_test_trial_division_defines.svh */
// Assertion macros for the trial-division primality tester.
// Included by the top level; depends on nothing else.
`ifndef PRIME_TEST_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_TEST_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ptd_pkg.sv */
// Package for the trial-division primality tester.
// Holds the sequencer state type and default constants; no dependencies.
`default_nettype none

package ptd_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIRST_DIVISOR   = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_NEXT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

/* sv/prime_test_trial_division.sv */
// The shared one-bit-per-cycle remainder unit sets the run time. The block takes one word
// at a time; the input is ready only while the sequencer is idle. Reset (synchronous,
// active low) returns the sequencer to idle and empties the output register.
// Top level of the trial-division primality tester; uses ptd_pkg and the defines header.
`default_nettype none
`include "prime_test_trial_division_defines.svh"

module prime_test_trial_division
    import ptd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_number,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_is_prime
);

    // Index width for walking the bits of the number, most significant first.
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    // The first divisor and its square; the square register has one spare bit because
    // the square of the divisor past the bound may exceed the largest number.
    localparam logic [VALUE_WIDTH-1:0] FIRST_D  = VALUE_WIDTH'(FIRST_DIVISOR);
    localparam logic [VALUE_WIDTH:0]   FIRST_SQ = (VALUE_WIDTH + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_n;        // number under test
    logic [VALUE_WIDTH-1:0] r_d;        // current trial divisor
    logic [VALUE_WIDTH:0]   r_sq;       // r_d squared, kept by running sums
    logic [VALUE_WIDTH-1:0] r_rem;      // partial remainder of r_n by r_d
    logic [BIT_W-1:0]       r_bit;      // bit of r_n being brought down
    logic                   r_result;   // verdict waiting for the output register
    logic                   r_out_valid;
    logic                   r_is_prime;

    // The shared unit: one restoring step of the remainder, bringing down one bit.
    logic [VALUE_WIDTH:0]   w_trial;
    logic                   w_fits;
    logic [VALUE_WIDTH-1:0] n_rem;
    // The square test that bounds the search, and the flag for zero and one.
    logic                   w_past_bound;
    logic                   w_below_two;
    // The output register can take a new verdict when it is empty or being emptied.
    logic                   w_slot_free;
    logic                   w_in_accept;

    always_comb begin
        w_trial      = {r_rem, r_n[r_bit]};
        w_fits       = (w_trial >= {1'b0, r_d});
        n_rem        = w_fits ? VALUE_WIDTH'(w_trial - {1'b0, r_d}) : VALUE_WIDTH'(w_trial);
        w_past_bound = (r_sq > {1'b0, r_n});
        w_below_two  = (r_n < FIRST_D);
        w_slot_free  = !r_out_valid || i_out_ready;
        w_in_accept  = i_in_valid && o_in_ready;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Zero and one are not prime; past the square bound with no divisor
                // found, the number is prime. Otherwise try the current divisor.
                if (w_below_two || w_past_bound) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_rem == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;
        o_is_prime  = r_is_prime;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers; they need no reset since the sequencer loads them first.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    r_n  <= i_number;
                    r_d  <= FIRST_D;
                    r_sq <= FIRST_SQ;
                end
            end
            S_CHECK: begin
                r_rem    <= '0;
                r_bit    <= BIT_W'(VALUE_WIDTH - 1);
                r_result <= !w_below_two;
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_bit <= r_bit - BIT_W'(1);
            end
            S_NEXT: begin
                if (r_rem == '0) begin
                    r_result <= 1'b0;
                end else begin
                    // (d + 1)^2 = d^2 + 2d + 1.
                    r_d  <= r_d + VALUE_WIDTH'(1);
                    r_sq <= r_sq + {r_d, 1'b1};
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    r_is_prime <= r_result;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A division is only started while the divisor is within the square bound.
    `PTD_ASSERT_IMP(a_div_in_bound, i_clk, i_rst_n, r_state == S_DIV,
        (r_sq <= {1'b0, r_n}), "trial divisor beyond the square bound")
    // The finished remainder is always smaller than the divisor.
    `PTD_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_NEXT,
        r_rem < r_d, "remainder not below the divisor")
    // An accepted word starts a fresh search at the first divisor.
    `PTD_ASSERT_NXT(a_start_search, i_clk, i_rst_n, w_in_accept,
        r_state == S_CHECK && r_d == FIRST_D, "search did not restart at the first divisor")
    // A new word appears at the output only after the sequencer has finished.
    `PTD_ASSERT_IMP(a_out_from_finish, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state == S_FINISH), "output word without a finished search")

endmodule

`default_nettype wire
